### hw/rtl/tbd_pkg.sv
`timescale 1ns / 1ps

package tbd_pkg;

	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;
	localparam logic [1:0] FMT_DXT5 = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [3:0] LAST_TEXEL_IDX = 4'd15;

	typedef enum logic [1:0] {
		ALPHA_OPAQUE,
		ALPHA_NIBBLE,
		ALPHA_PALETTE
	} amode_t;

	typedef struct packed {
		logic [63:0] first_word;
		logic [63:0] second_word;
	} in_t;

	typedef struct packed {
		logic [3:0] texel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_texel;
	} out_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// one decoded block as the back end sees it
	typedef struct packed {
		rgb_t [3:0]      cpal;
		logic [7:0][7:0] apal;
		logic [31:0]     cidx;
		logic [63:0]     aword;
		amode_t          amode;
	} entry_t;

	typedef struct packed {
		logic              push;
		entry_t            data;
	} qpush_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} qstat_t;

endpackage

### hw/rtl/tbd_front.sv
`timescale 1ns / 1ps

module tbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  tbd_pkg::in_t      in_data,
	input  tbd_pkg::qstat_t   qstat,
	output tbd_pkg::qpush_t   qpush
);

	logic [1:0] mode_q;

	// stage 1: expanded endpoints and weighted sums
	logic                v_s1;
	tbd_pkg::rgb_t       p0_s1, p1_s1;
	logic [8:0]          mr_s1, mg_s1, mb_s1;
	logic [9:0]          s2r_s1, s2g_s1, s2b_s1, s3r_s1, s3g_s1, s3b_s1;
	logic                four_s1;
	logic [7:0]          a0_s1, a1_s1;
	logic                agt_s1;
	logic [10:0]         sev_s1 [1:6];
	logic [10:0]         fiv_s1 [1:4];
	logic [31:0]         cidx_s1;
	logic [63:0]         aword_s1;
	tbd_pkg::amode_t     amode_s1;

	logic [63:0]         colour;
	logic                dxt1;
	logic [15:0]         c0, c1;
	tbd_pkg::rgb_t       p0, p1;
	tbd_pkg::rgb_t       sa, sb;
	logic [7:0]          a0, a1;
	logic [10:0]         sev [1:6];
	logic [10:0]         fiv [1:4];
	tbd_pkg::amode_t     amode;
	logic                in_fire;

	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] prod;
		prod = 21'(x) * 21'd683;
		return prod[18:11];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] prod;
		prod = 22'(x) * 22'd1639;
		return prod[20:13];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] prod;
		prod = 23'(x) * 23'd2341;
		return prod[21:14];
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (qstat.count + tbd_pkg::QCNT_W'(v_s1)) <
		tbd_pkg::QCNT_W'(tbd_pkg::QDEPTH);
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tbd_pkg::FMT_DXT1;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	always_comb begin
		dxt1   = (mode_q == tbd_pkg::FMT_DXT1);
		colour = dxt1 ? in_data.first_word : in_data.second_word;
		c0     = colour[15:0];
		c1     = colour[31:16];
		p0     = '{r: {c0[15:11], 3'b0}, g: {c0[10:5], 2'b0}, b: {c0[4:0], 3'b0}};
		p1     = '{r: {c1[15:11], 3'b0}, g: {c1[10:5], 2'b0}, b: {c1[4:0], 3'b0}};
		a0     = in_data.first_word[7:0];
		a1     = in_data.first_word[15:8];
		for (int k = 1; k <= 6; k++) begin
			sev[k] = 11'((7 - k) * a0) + 11'(k * a1);
		end
		for (int k = 1; k <= 4; k++) begin
			fiv[k] = 11'((5 - k) * a0) + 11'(k * a1);
		end
		case (mode_q)
			tbd_pkg::FMT_DXT1: amode = tbd_pkg::ALPHA_OPAQUE;
			tbd_pkg::FMT_DXT3: amode = tbd_pkg::ALPHA_NIBBLE;
			default:           amode = tbd_pkg::ALPHA_PALETTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			p0_s1    <= p0;
			p1_s1    <= p1;
			s2r_s1   <= {1'b0, p0.r, 1'b0} + 10'(p1.r);
			s2g_s1   <= {1'b0, p0.g, 1'b0} + 10'(p1.g);
			s2b_s1   <= {1'b0, p0.b, 1'b0} + 10'(p1.b);
			s3r_s1   <= 10'(p0.r) + {1'b0, p1.r, 1'b0};
			s3g_s1   <= 10'(p0.g) + {1'b0, p1.g, 1'b0};
			s3b_s1   <= 10'(p0.b) + {1'b0, p1.b, 1'b0};
			mr_s1    <= 9'(p0.r) + 9'(p1.r);
			mg_s1    <= 9'(p0.g) + 9'(p1.g);
			mb_s1    <= 9'(p0.b) + 9'(p1.b);
			four_s1  <= !dxt1 || (c0 > c1);
			a0_s1    <= a0;
			a1_s1    <= a1;
			agt_s1   <= a0 > a1;
			sev_s1   <= sev;
			fiv_s1   <= fiv;
			cidx_s1  <= colour[63:32];
			aword_s1 <= in_data.first_word;
			amode_s1 <= amode;
		end
	end

	// stage 2: reciprocal divides, result goes straight into the queue
	always_comb begin
		sa = '{r: div3(s2r_s1), g: div3(s2g_s1), b: div3(s2b_s1)};
		sb = '{r: div3(s3r_s1), g: div3(s3g_s1), b: div3(s3b_s1)};
		qpush.push         = v_s1;
		qpush.data.cpal[0] = p0_s1;
		qpush.data.cpal[1] = p1_s1;
		if (four_s1) begin
			qpush.data.cpal[2] = sa;
			qpush.data.cpal[3] = sb;
		end else begin
			qpush.data.cpal[2] = '{r: mr_s1[8:1], g: mg_s1[8:1], b: mb_s1[8:1]};
			qpush.data.cpal[3] = '0;
		end
		qpush.data.apal[0] = a0_s1;
		qpush.data.apal[1] = a1_s1;
		if (agt_s1) begin
			for (int k = 1; k <= 6; k++) begin
				qpush.data.apal[k + 1] = div7(sev_s1[k]);
			end
		end else begin
			for (int k = 1; k <= 4; k++) begin
				qpush.data.apal[k + 1] = div5(fiv_s1[k]);
			end
			qpush.data.apal[6] = 8'd0;
			qpush.data.apal[7] = 8'd255;
		end
		qpush.data.cidx  = cidx_s1;
		qpush.data.aword = aword_s1;
		qpush.data.amode = amode_s1;
	end

endmodule

### hw/rtl/tbd_queue.sv
`timescale 1ns / 1ps

module tbd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  tbd_pkg::qpush_t   qpush,
	input  logic              pop,
	output tbd_pkg::qstat_t   qstat,
	output tbd_pkg::entry_t   head
);

	tbd_pkg::entry_t                 mem_q [tbd_pkg::QDEPTH];
	logic [tbd_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [tbd_pkg::QCNT_W-1:0]      count_q;

	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qpush.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({qpush.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (qpush.push) begin
			mem_q[wr_ptr_q] <= qpush.data;
		end
	end

endmodule

### hw/rtl/tbd_back.sv
`timescale 1ns / 1ps

module tbd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tbd_pkg::qstat_t   qstat,
	input  tbd_pkg::entry_t   head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output tbd_pkg::out_t     out_data
);

	logic [3:0]       tex_q;
	logic             valid_q;
	tbd_pkg::out_t    out_q;
	logic             advance;
	logic [1:0]       ci;
	logic [2:0]       ai;
	tbd_pkg::rgb_t    col;
	logic [7:0]       alpha;

	assign advance   = !qstat.empty && (!valid_q || out_ready);
	assign pop       = advance && (tex_q == tbd_pkg::LAST_TEXEL_IDX);
	assign out_valid = valid_q;
	assign out_data  = out_q;

	always_comb begin
		ci  = head.cidx[{tex_q, 1'b0} +: 2];
		ai  = head.aword[6'd16 + 6'(tex_q) * 6'd3 +: 3];
		col = head.cpal[ci];
		case (head.amode)
			tbd_pkg::ALPHA_OPAQUE: alpha = 8'd255;
			tbd_pkg::ALPHA_NIBBLE: alpha = {head.aword[{tex_q, 2'b0} +: 4], 4'b0};
			default:               alpha = head.apal[ai];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				tex_q   <= tex_q + 1'b1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.texel_index <= tex_q;
			out_q.red         <= col.r;
			out_q.green       <= col.g;
			out_q.blue        <= col.b;
			out_q.alpha       <= alpha;
			out_q.last_texel  <= (tex_q == tbd_pkg::LAST_TEXEL_IDX);
		end
	end

endmodule

### hw/rtl/texture_block_decoder_top.sv
`timescale 1ns / 1ps

// S3TC block decoder. Each transfer on the input takes one 4x4 block as two
// little-endian 64-bit words; the output then gives its 16 RGBA texels in
// row-major order, one per transfer, with last_texel set on the sixteenth.
// cfg_data selects DXT1, DXT3 or DXT5 (code 3 acts as DXT5); write it only
// while no block is in flight. Throughput is one texel per cycle while the queue
// holds a block and out_ready is high, set by the single texel-wide output
// register. With the queue empty, a block's transfer loads the expanded
// endpoints and weighted sums into the stage-1 registers, the divided palettes
// are then written into a four-block queue, and the output register is loaded
// from the queue head. The queue lets new blocks be taken while earlier ones
// still stream out.
module texture_block_decoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  tbd_pkg::in_t      in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tbd_pkg::out_t     out_data
);

	tbd_pkg::qpush_t qpush;
	tbd_pkg::qstat_t qstat;
	tbd_pkg::entry_t head;
	logic            pop;

	tbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.qstat     (qstat),
		.qpush     (qpush)
	);

	tbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	tbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### hw/rtl/tbd_checker.sv
`timescale 1ns / 1ps

module tbd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input tbd_pkg::out_t   out_data
);

	// stalled output holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// end-of-block flag tracks the texel position
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_texel == (out_data.texel_index == tbd_pkg::LAST_TEXEL_IDX)))
		else $error("last_texel does not match texel_index");

	// texel positions step by one across transfers
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid |->
			out_data.texel_index == $past(out_data.texel_index) + 4'd1)
		else $error("texel order broken");

	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind texture_block_decoder_top tbd_checker u_tbd_checker (.*);
